// ----- rtl/ctp_pkg.sv -----
// ctp_pkg: shared types, widths and constants for the cartesian_to_polar block.
// Used by ctp_prep, ctp_stage, ctp_post and the cartesian_to_polar top level.
// No dependencies.
package ctp_pkg;

  localparam int IN_WIDTH    = 16;
  localparam int MAG_WIDTH   = IN_WIDTH + 4;
  localparam int PHASE_WIDTH = 16;

  // CORDIC datapath: components scaled by 2^FRAC_BITS, with headroom for the gain
  localparam int FRAC_BITS = 24;
  localparam int CW        = IN_WIDTH + FRAC_BITS + 3;
  localparam int ZW        = 32;
  localparam int ATAN_LEN  = 24;

  // square root: one result bit per digit, two radicand bits per digit
  localparam int SQ_DIGITS = MAG_WIDTH;
  localparam int REM_W     = SQ_DIGITS + 2;
  localparam int VAL_W     = 2 * SQ_DIGITS;

  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int ROUND_HALF  = 65536;
  localparam int ANGLE_SHIFT = 17;

  // atan(2^-i) in Q30, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] x_value;
    logic signed [IN_WIDTH-1:0] y_value;
    logic                       last_in;
  } sample_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0]          magnitude;
    logic signed [PHASE_WIDTH-1:0] phase;
    logic                          last_out;
  } polar_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic last;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic [SQ_DIGITS-1:0] root;
    logic [REM_W-1:0]     rem;
    logic [VAL_W-1:0]     vsh;
    side_t                side;
  } core_t;

endpackage

// ----- rtl/ctp_prep.sv -----
// ctp_prep: front of the pipeline. Folds the vector into the first quadrant,
// squares the components and builds the initial CORDIC / square-root word.
// Depends on ctp_pkg.
module ctp_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             take,
  input  ctp_pkg::sample_t item,
  output logic             core_valid,
  output ctp_pkg::core_t   core
);

  localparam int W = ctp_pkg::IN_WIDTH;

  // stage 1: absolute values and flags
  logic              p1_valid;
  logic [W-1:0]      ax;
  logic [W-1:0]      ay;
  ctp_pkg::side_t    side1;

  // stage 2: squares
  logic              p2_valid;
  logic [2*W-1:0]    sq_x;
  logic [2*W-1:0]    sq_y;
  logic [W-1:0]      ax2;
  logic [W-1:0]      ay2;
  ctp_pkg::side_t    side2;

  logic [2*W-1:0]    sq_sum;
  ctp_pkg::core_t    core_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      core_valid <= 1'b0;
    end else if (en) begin
      p1_valid   <= take;
      p2_valid   <= p1_valid;
      core_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= item.x_value[W-1] ? W'(~item.x_value + 1'b1) : item.x_value;
      ay <= item.y_value[W-1] ? W'(~item.y_value + 1'b1) : item.y_value;
      side1.x_zero <= (item.x_value == '0);
      side1.y_zero <= (item.y_value == '0);
      side1.x_neg  <= item.x_value[W-1];
      side1.y_neg  <= item.y_value[W-1];
      side1.last   <= item.last_in;

      sq_x  <= {{W{1'b0}}, ax} * {{W{1'b0}}, ax};
      sq_y  <= {{W{1'b0}}, ay} * {{W{1'b0}}, ay};
      ax2   <= ax;
      ay2   <= ay;
      side2 <= side1;

      core <= core_next;
    end
  end

  always_comb begin
    // x^2 + y^2 never exceeds 2^(2W-1), so the sum fits in 2W bits
    sq_sum = sq_x + sq_y;
    core_next.cx   = $signed({{(ctp_pkg::CW-W-ctp_pkg::FRAC_BITS){1'b0}}, ax2,
                              {ctp_pkg::FRAC_BITS{1'b0}}});
    core_next.cy   = $signed({{(ctp_pkg::CW-W-ctp_pkg::FRAC_BITS){1'b0}}, ay2,
                              {ctp_pkg::FRAC_BITS{1'b0}}});
    core_next.z    = '0;
    core_next.root = '0;
    core_next.rem  = '0;
    core_next.vsh  = {sq_sum, 8'h00};
    core_next.side = side2;
  end

endmodule

// ----- rtl/ctp_stage.sv -----
// ctp_stage: one pipeline stage doing a CORDIC vectoring micro-rotation and
// one digit of the restoring square root, each only where enabled.
// Depends on ctp_pkg.
module ctp_stage #(
  parameter int IDX    = 0,
  parameter bit ROT_EN = 1'b1,
  parameter bit DIG_EN = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           up_valid,
  input  ctp_pkg::core_t up,
  output logic           dn_valid,
  output ctp_pkg::core_t dn
);

  localparam int TI = (IDX < ctp_pkg::ATAN_LEN) ? IDX : 0;
  localparam int D  = ctp_pkg::SQ_DIGITS;
  localparam int RW = ctp_pkg::REM_W;
  localparam int VW = ctp_pkg::VAL_W;

  logic signed [ctp_pkg::CW-1:0] x_in;
  logic signed [ctp_pkg::CW-1:0] y_in;
  logic signed [ctp_pkg::CW-1:0] dx;
  logic signed [ctp_pkg::CW-1:0] dy;
  logic [RW-1:0]                 rem_sh;
  logic [RW-1:0]                 trial;
  ctp_pkg::core_t                dn_next;

  always_comb begin
    x_in = up.cx;
    y_in = up.cy;
    dx   = y_in >>> TI;
    dy   = x_in >>> TI;
    rem_sh = {up.rem[RW-3:0], up.vsh[VW-1 -: 2]};
    trial  = {up.root, 2'b01};

    dn_next = up;
    if (ROT_EN) begin
      if (!y_in[ctp_pkg::CW-1]) begin
        dn_next.cx = x_in + dx;
        dn_next.cy = y_in - dy;
        dn_next.z  = up.z + ctp_pkg::ATAN_Q30[TI];
      end else begin
        dn_next.cx = x_in - dx;
        dn_next.cy = y_in + dy;
        dn_next.z  = up.z - ctp_pkg::ATAN_Q30[TI];
      end
    end
    if (DIG_EN) begin
      dn_next.vsh = {up.vsh[VW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        dn_next.rem  = rem_sh - trial;
        dn_next.root = {up.root[D-2:0], 1'b1};
      end else begin
        dn_next.rem  = rem_sh;
        dn_next.root = {up.root[D-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

// ----- rtl/ctp_post.sv -----
// ctp_post: rounds the CORDIC angle to Q13, clamps it to the first quadrant and
// maps it to the true quadrant, with the zero-axis special cases.
// Depends on ctp_pkg.
module ctp_post (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            up_valid,
  input  ctp_pkg::core_t  up,
  output logic            res_valid,
  output ctp_pkg::polar_t res
);

  localparam int ZW = ctp_pkg::ZW;
  localparam int PW = ctp_pkg::PHASE_WIDTH;
  localparam int AW = ZW + 1 - ctp_pkg::ANGLE_SHIFT;

  logic signed [ZW:0]   z_round;
  logic signed [AW-1:0] a_raw;
  logic signed [PW-1:0] alpha_next;

  logic                             q1_valid;
  logic signed [PW-1:0]             alpha;
  logic [ctp_pkg::MAG_WIDTH-1:0]    mag;
  ctp_pkg::side_t                   side;

  logic signed [PW-1:0] pi_c;
  logic signed [PW-1:0] half_c;
  ctp_pkg::polar_t      res_next;

  always_comb begin
    z_round = {up.z[ZW-1], up.z} + (ZW+1)'(ctp_pkg::ROUND_HALF);
    a_raw   = z_round[ZW:ctp_pkg::ANGLE_SHIFT];
    if (a_raw < 0) begin
      alpha_next = '0;
    end else if (a_raw > AW'(ctp_pkg::HALF_PI_Q13)) begin
      alpha_next = PW'(ctp_pkg::HALF_PI_Q13);
    end else begin
      alpha_next = PW'(a_raw);
    end
  end

  always_comb begin
    pi_c   = PW'(ctp_pkg::PI_Q13);
    half_c = PW'(ctp_pkg::HALF_PI_Q13);
    res_next.magnitude = mag;
    res_next.last_out  = side.last;
    if (side.x_zero && side.y_zero) begin
      res_next.phase = '0;
    end else if (side.x_zero) begin
      res_next.phase = side.y_neg ? -half_c : half_c;
    end else if (side.y_zero) begin
      // negative real axis maps to +pi, never -pi
      res_next.phase = side.x_neg ? pi_c : '0;
    end else if (!side.x_neg) begin
      res_next.phase = side.y_neg ? -alpha : alpha;
    end else begin
      res_next.phase = side.y_neg ? (alpha - pi_c) : (pi_c - alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      q1_valid  <= up_valid;
      res_valid <= q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha <= alpha_next;
      mag   <= up.root;
      side  <= up.side;
      res   <= res_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.phase <= PW'(ctp_pkg::PI_Q13)) &&
                   (res.phase >= -(PW'(ctp_pkg::PI_Q13)))))
    else $error("phase outside [-pi, pi]");

endmodule

// ----- rtl/cartesian_to_polar.sv -----
// cartesian_to_polar: magnitude and four-quadrant angle of a signed vector.
// Throughput: one item per cycle while the pipeline is not frozen; each ctp_stage
// holds at most one CORDIC rotation and at most one square-root digit. A two-entry
// output buffer takes results while the consumer stalls; the pipeline freezes only
// once both entries are full.
// Reset (rst, synchronous) clears valid bits only; no clearing pass.
module cartesian_to_polar #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  ctp_pkg::sample_t sample,
  output logic             polar_valid,
  input  logic             polar_stall,
  output ctp_pkg::polar_t  polar
);

  localparam int CN = (CORDIC_STAGES > ctp_pkg::ATAN_LEN) ? ctp_pkg::ATAN_LEN
                                                          : CORDIC_STAGES;
  localparam int L  = (CN > ctp_pkg::SQ_DIGITS) ? CN : ctp_pkg::SQ_DIGITS;

  logic             en;
  logic             take;
  logic [L:0]       chain_valid;
  ctp_pkg::core_t   chain [L+1];
  logic             res_valid;
  ctp_pkg::polar_t  res;
  logic             skid_valid;
  ctp_pkg::polar_t  skid;
  logic             arrive;

  assign en           = !skid_valid;
  assign sample_stall = skid_valid;
  assign take         = sample_valid && !sample_stall;

  ctp_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .take       (take),
    .item       (sample),
    .core_valid (chain_valid[0]),
    .core       (chain[0])
  );

  for (genvar k = 0; k < L; k++) begin : g_stage
    ctp_stage #(
      .IDX    (k),
      .ROT_EN (k < CN),
      .DIG_EN (k < ctp_pkg::SQ_DIGITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (chain_valid[k]),
      .up       (chain[k]),
      .dn_valid (chain_valid[k+1]),
      .dn       (chain[k+1])
    );
  end

  ctp_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .up_valid  (chain_valid[L]),
    .up        (chain[L]),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register plus skid entry
  assign arrive = res_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      polar_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!polar_valid || !polar_stall) begin
      if (skid_valid) begin
        polar_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        polar_valid <= arrive;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!polar_valid || !polar_stall) begin
      polar <= skid_valid ? skid : res;
    end else if (arrive) begin
      skid <= res;
    end
  end

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(polar_valid && polar_stall))
    else $error("skid entry filled while output was free");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> polar_valid)
    else $error("skid entry holds data with output register empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (polar_valid && polar_stall) |=> (polar_valid && $stable(polar)))
    else $error("stalled result changed");

endmodule

// ----- test/cartesian_to_polar_tb.sv -----
// cartesian_to_polar_tb: self-checking testbench for the cartesian_to_polar block.
// Predicts magnitude and four-quadrant angle per transfer and scoreboards results.
// Depends on ctp_pkg and the cartesian_to_polar RTL.
`timescale 1ns / 1ps

module cartesian_to_polar_tb;

  localparam int IN_WIDTH      = ctp_pkg::IN_WIDTH;
  localparam int MAG_WIDTH     = ctp_pkg::MAG_WIDTH;
  localparam int PHASE_WIDTH   = ctp_pkg::PHASE_WIDTH;
  localparam int PI_Q13        = ctp_pkg::PI_Q13;
  localparam int HALF_PI_Q13   = ctp_pkg::HALF_PI_Q13;

  localparam int CORDIC_STAGES = 16;
  localparam int RANDOM_ITEMS  = 950;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RUN_LIMIT     = 600000;
  localparam int SQUEEZE_AFTER = 400;     // inputs sent before the long receiver hold-off
  localparam int SQUEEZE_LEN   = 300;

  // atan(2^-i) in Q30
  localparam longint ATAN_STEPS [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  localparam int DIR_N = 22;
  localparam int DIR_X [DIR_N] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, 1, -1,
                                   -1, 1, 32767, -32768, -32768, 32767, 32767, 1,
                                   -32768, -3, 100};
  localparam int DIR_Y [DIR_N] = '{0, 1, -1, 32767, -32768, 0, 0, 0, 0, 1, 1,
                                   -1, -1, 32767, -32768, 32767, -32768, 1, 32767,
                                   -1, 4, -99};

  class polar_scoreboard;
    ctp_pkg::polar_t expected_q[$];
    int              mismatches;

    function new();
      mismatches = 0;
    endfunction

    // floor(16*sqrt(x^2+y^2)) and the CORDIC angle, folded to the true quadrant
    function ctp_pkg::polar_t polar_of(ctp_pkg::sample_t s);
      longint x, y, ax, ay, rad, root, bitv, xs, ys, z, dx, dy, alpha;
      int     ph, i;
      ctp_pkg::polar_t r;
      x  = longint'($signed(s.x_value));
      y  = longint'($signed(s.y_value));
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;

      rad  = (ax * ax + ay * ay) << 8;
      root = 0;
      bitv = longint'(1) << 40;
      while (bitv > rad) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rad >= root + bitv) begin
          rad  = rad - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end

      if (x == 0 && y == 0) begin
        ph = 0;
      end else if (x == 0) begin
        ph = (y > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
      end else if (y == 0) begin
        ph = (x > 0) ? 0 : PI_Q13;   // negative x axis maps to +pi
      end else begin
        xs = ax <<< 24;
        ys = ay <<< 24;
        z  = 0;
        for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
          dx = ys >>> i;
          dy = xs >>> i;
          if (ys >= 0) begin
            xs = xs + dx;
            ys = ys - dy;
            z  = z + ATAN_STEPS[i];
          end else begin
            xs = xs - dx;
            ys = ys + dy;
            z  = z - ATAN_STEPS[i];
          end
        end
        alpha = (z + 65536) >>> 17;
        if (alpha < 0) alpha = 0;
        if (alpha > HALF_PI_Q13) alpha = HALF_PI_Q13;
        if (x > 0) ph = (y > 0) ? int'(alpha) : -int'(alpha);
        else       ph = (y > 0) ? PI_Q13 - int'(alpha) : int'(alpha) - PI_Q13;
      end

      r.magnitude = MAG_WIDTH'(root);
      r.phase     = PHASE_WIDTH'(ph);
      r.last_out  = s.last_in;
      return r;
    endfunction

    function void note_sample(ctp_pkg::sample_t s);
      expected_q.push_back(polar_of(s));
    endfunction

    function void check_result(ctp_pkg::polar_t got);
      ctp_pkg::polar_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result mag %0d phase %0d last %0d",
                   got.magnitude, $signed(got.phase), got.last_out);
        return;
      end
      want = expected_q.pop_front();
      if (got.magnitude !== want.magnitude || got.phase !== want.phase ||
          got.last_out !== want.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected mag %0d phase %0d last %0d, ",
                    "got mag %0d phase %0d last %0d"},
                   want.magnitude, $signed(want.phase), want.last_out,
                   got.magnitude, $signed(got.phase), got.last_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  ctp_pkg::sample_t sample;
  logic             polar_valid;
  logic             polar_stall;
  ctp_pkg::polar_t  polar;

  polar_scoreboard board;
  int inputs_sent = 0;
  int cycle_count = 0;

  cartesian_to_polar #(.CORDIC_STAGES(CORDIC_STAGES)) i_dut (
    .clk,
    .rst,
    .sample_valid,
    .sample_stall,
    .sample,
    .polar_valid,
    .polar_stall,
    .polar
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic ctp_pkg::sample_t random_sample();
    ctp_pkg::sample_t s;
    int      kind;
    int      picks [6];
    logic signed [IN_WIDTH-1:0] x, y;
    picks = '{-32768, -32767, -1, 0, 1, 32767};
    kind  = $urandom_range(0, 99);
    if (kind < 40) begin
      x = IN_WIDTH'($urandom);
      y = IN_WIDTH'($urandom);
    end else if (kind < 60) begin
      x = IN_WIDTH'(int'($urandom_range(0, 16)) - 8);
      y = IN_WIDTH'(int'($urandom_range(0, 16)) - 8);
    end else if (kind < 70) begin
      // one component on an axis
      x = IN_WIDTH'($urandom);
      y = '0;
      if ($urandom_range(0, 1)) begin
        y = x;
        x = '0;
      end
    end else if (kind < 80) begin
      x = IN_WIDTH'(picks[$urandom_range(0, 5)]);
      y = IN_WIDTH'(picks[$urandom_range(0, 5)]);
    end else begin
      // near the diagonals, where the rotation direction flips often
      x = IN_WIDTH'($urandom);
      y = x + IN_WIDTH'(int'($urandom_range(0, 6)) - 3);
      if ($urandom_range(0, 1)) y = -y;
    end
    s.x_value = x;
    s.y_value = y;
    s.last_in = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_sample(ctp_pkg::sample_t s, int gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    board.note_sample(s);
    inputs_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && polar_valid && !polar_stall)
      board.check_result(polar);
  end

  initial begin : consumer
    int hold;
    bit squeezed;
    squeezed = 1'b0;
    polar_stall <= 1'b0;
    @(negedge clk);
    forever begin
      if (!squeezed && inputs_sent >= SQUEEZE_AFTER) begin
        // long hold-off while the sender keeps offering: pipeline fills and stalls
        squeezed = 1'b1;
        hold = SQUEEZE_LEN;
      end else begin
        hold = idle_len();
      end
      if (hold > 0) begin
        polar_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      polar_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 150)) @(negedge clk);
      else repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  initial begin : stimulus
    int               i;
    bit               steady;
    ctp_pkg::sample_t s;
    board = new();
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++) begin
      s.x_value = IN_WIDTH'(DIR_X[i]);
      s.y_value = IN_WIDTH'(DIR_Y[i]);
      s.last_in = (i % 3 == 2);
      offer_sample(s, idle_len());
    end

    steady = 1'b0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      offer_sample(random_sample(), steady ? 0 : idle_len());
    end
    sample_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
